>>> design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the page frame allocator: request and
// result items, table entry layout, memory request bundles, and codes.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // Pool geometry and count width.
    localparam int PAGE_W   = 14;
    localparam int TOP_W    = PAGE_W + 1;
    localparam int REF_BITS = 16;
    localparam int NUM_PAGES_INT = 16384;

    localparam logic [TOP_W-1:0]    NUM_PAGES = TOP_W'(NUM_PAGES_INT);
    localparam logic [PAGE_W-1:0]   LAST_PAGE = PAGE_W'(NUM_PAGES_INT - 1);
    localparam logic [REF_BITS-1:0] REF_MAX   = '1;
    localparam logic [REF_BITS-1:0] REF_ONE   = REF_BITS'(1);

    // Request codes.
    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_ALLOC  = 3'd1;
    localparam logic [2:0] REQ_FREE   = 3'd2;
    localparam logic [2:0] REQ_ADDREF = 3'd3;
    localparam logic [2:0] REQ_QUERY  = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_DEFERRED  = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_FAULT     = 3'd4;

    // Input item.
    typedef struct packed {
        logic [2:0]        req_type;
        logic [PAGE_W-1:0] page;
    } t_req;

    // Result item.
    typedef struct packed {
        logic [2:0]          status;
        logic [PAGE_W-1:0]   frame;
        logic [REF_BITS-1:0] ref_count;
        logic                is_managed;
        logic [TOP_W-1:0]    free_count;
    } t_rsp;

    // One frame's record in the frame table.
    typedef struct packed {
        logic [REF_BITS-1:0] ref_cnt;
        logic                managed;
        logic                is_free;
    } t_entry;

    // Frame table access from the controller.
    typedef struct packed {
        logic              rd_en;
        logic [PAGE_W-1:0] rd_addr;
        logic              wr_en;
        logic [PAGE_W-1:0] wr_addr;
        t_entry            wr_data;
    } t_tbl_req;

    // Free stack access from the controller.
    typedef struct packed {
        logic              rd_en;
        logic [PAGE_W-1:0] rd_addr;
        logic              wr_en;
        logic [PAGE_W-1:0] wr_addr;
        logic [PAGE_W-1:0] wr_data;
    } t_stk_req;

    // Status of the post-reset table clearing sweep.
    typedef struct packed {
        logic              busy;
        logic [PAGE_W-1:0] addr;
    } t_clr;

endpackage

>>> design/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/pfa_clear.sv
// ----------------------------------------------------------------------------
// pfa_clear
// Sweeps the frame table once after reset, one entry per cycle, so that
// every frame starts unmanaged, not free and with a zero count.
// ----------------------------------------------------------------------------
module pfa_clear (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output pfa_pkg::t_clr o_clr
);

    logic                      r_busy;
    logic [pfa_pkg::PAGE_W-1:0] r_addr;

    // Address counter runs from the first to the last frame, then stops.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else if (r_busy) begin
            r_addr <= r_addr + 1'b1;
            if (r_addr == pfa_pkg::LAST_PAGE) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_clr.busy = r_busy;
    assign o_clr.addr = r_addr;

endmodule

>>> design/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Request sequencer: reads the frame table and the free stack, decides the
// request, writes the modified entry back, pushes or pops the stack, and
// holds the result item in an output register.
// ----------------------------------------------------------------------------
module pfa_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfa_pkg::t_clr               i_clr,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  pfa_pkg::t_req               i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output pfa_pkg::t_rsp               o_out_item,
    output pfa_pkg::t_tbl_req           o_tbl,
    input  pfa_pkg::t_entry             i_tbl_rd_data,
    output pfa_pkg::t_stk_req           o_stk,
    input  logic [pfa_pkg::PAGE_W-1:0]  i_stk_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC
    } t_state;

    t_state                       r_state;
    pfa_pkg::t_req                r_req;
    logic [pfa_pkg::PAGE_W-1:0]   r_frame;
    logic [pfa_pkg::TOP_W-1:0]    r_top;
    logic                         r_out_valid;
    pfa_pkg::t_rsp                r_out_item;

    logic                         accept;
    logic                         out_free;
    logic                         exec_go;
    logic                         page_ok;
    logic                         top_zero;
    pfa_pkg::t_entry              cur;
    pfa_pkg::t_entry              n_entry;
    logic [2:0]                   n_status;
    logic [pfa_pkg::PAGE_W-1:0]   n_frame;
    logic                         wr;
    logic                         push;
    logic                         pop;
    logic                         rep_valid;
    logic [pfa_pkg::TOP_W-1:0]    n_top;
    pfa_pkg::t_rsp                n_rsp;

    // Handshake: one item at a time, none during the clearing sweep.
    assign o_in_ready = (r_state == S_IDLE) && !i_clr.busy;
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign exec_go    = (r_state == S_EXEC) && out_free;

    assign cur      = i_tbl_rd_data;
    assign page_ok  = {1'b0, r_req.page} < pfa_pkg::NUM_PAGES;
    assign top_zero = (r_top == '0);

    // Decide the request from the entry read out of the table.
    always_comb begin
        n_entry   = cur;
        n_status  = pfa_pkg::ST_OK;
        n_frame   = '0;
        wr        = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        rep_valid = page_ok;
        case (r_req.req_type)
            pfa_pkg::REQ_ADD: begin
                if (!page_ok || cur.managed) begin
                    n_status = pfa_pkg::ST_FAULT;
                end else begin
                    n_entry.ref_cnt = '0;
                    n_entry.managed = 1'b1;
                    n_entry.is_free = 1'b1;
                    wr              = 1'b1;
                    push            = 1'b1;
                end
            end
            pfa_pkg::REQ_ALLOC: begin
                if (top_zero) begin
                    n_status  = pfa_pkg::ST_EMPTY;
                    rep_valid = 1'b0;
                end else begin
                    pop             = 1'b1;
                    n_frame         = r_frame;
                    n_entry.ref_cnt = pfa_pkg::REF_ONE;
                    n_entry.is_free = 1'b0;
                    wr              = 1'b1;
                    rep_valid       = 1'b1;
                end
            end
            pfa_pkg::REQ_FREE: begin
                if (!page_ok || !cur.managed) begin
                    n_status = pfa_pkg::ST_FAULT;
                end else if (cur.ref_cnt == '0) begin
                    n_status = cur.is_free ? pfa_pkg::ST_DUPLICATE : pfa_pkg::ST_FAULT;
                end else begin
                    n_entry.ref_cnt = cur.ref_cnt - 1'b1;
                    wr              = 1'b1;
                    if (n_entry.ref_cnt != '0) begin
                        n_status = pfa_pkg::ST_DEFERRED;
                    end else begin
                        n_entry.is_free = 1'b1;
                        push            = 1'b1;
                    end
                end
            end
            pfa_pkg::REQ_ADDREF: begin
                if (!page_ok || !cur.managed || cur.ref_cnt == '0 ||
                    cur.ref_cnt == pfa_pkg::REF_MAX) begin
                    n_status = pfa_pkg::ST_FAULT;
                end else begin
                    n_entry.ref_cnt = cur.ref_cnt + 1'b1;
                    n_entry.is_free = 1'b0;
                    wr              = 1'b1;
                end
            end
            pfa_pkg::REQ_QUERY: begin
                n_status = pfa_pkg::ST_OK;
            end
            default: begin
                n_status = pfa_pkg::ST_FAULT;
            end
        endcase
    end

    // Stack pointer update; a push beyond a full stack is dropped.
    always_comb begin
        n_top = r_top;
        if (push && (r_top < pfa_pkg::NUM_PAGES)) begin
            n_top = r_top + 1'b1;
        end else if (pop) begin
            n_top = r_top - 1'b1;
        end
    end

    // Result item of the current request.
    always_comb begin
        n_rsp.status     = n_status;
        n_rsp.frame      = n_frame;
        n_rsp.ref_count  = '0;
        n_rsp.is_managed = 1'b0;
        n_rsp.free_count = n_top;
        if (rep_valid && n_entry.managed) begin
            n_rsp.ref_count  = n_entry.ref_cnt;
            n_rsp.is_managed = 1'b1;
        end
    end

    // Frame table access: read on accept, reread at the popped frame for
    // an allocate, write back during execution.
    always_comb begin
        o_tbl.rd_en   = accept ||
                        ((r_state == S_LOOK) && (r_req.req_type == pfa_pkg::REQ_ALLOC));
        o_tbl.rd_addr = accept ? i_in_item.page : i_stk_rd_data;
        o_tbl.wr_en   = exec_go && wr;
        o_tbl.wr_addr = pop ? r_frame : r_req.page;
        o_tbl.wr_data = n_entry;
    end

    // Free stack access: read the top entry on accept, push during execution.
    always_comb begin
        o_stk.rd_en   = accept;
        o_stk.rd_addr = r_top[pfa_pkg::PAGE_W-1:0] - 1'b1;
        o_stk.wr_en   = exec_go && push && (r_top < pfa_pkg::NUM_PAGES);
        o_stk.wr_addr = r_top[pfa_pkg::PAGE_W-1:0];
        o_stk.wr_data = r_req.page;
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result replaces the one leaving in the same cycle.
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req   <= i_in_item;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_frame <= i_stk_rd_data;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_top      <= n_top;
                        r_out_item <= n_rsp;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> design/refcounted_page_frame_allocator.sv
// Sequencing: an accepted request item passes the look and execute states; its
// result item is registered on leaving execute, which waits for a free output.
// One item at a time: the table read, the dependent reread at the popped frame
// and the write-back finish before the next is accepted. Reset: synchronous,
// active low; a sweep then clears the table, one entry per cycle, taking no items.
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator
// Page frame allocator with per-frame reference counts, a managed flag, a
// free flag and a LIFO free stack, kept in two synchronous memories.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pfa_pkg::t_req i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pfa_pkg::t_rsp o_out_item
);

    pfa_pkg::t_clr              clr;
    pfa_pkg::t_tbl_req          tbl;
    pfa_pkg::t_stk_req          stk;
    pfa_pkg::t_entry            tbl_rd_data;
    logic [pfa_pkg::PAGE_W-1:0] stk_rd_data;
    logic                       tbl_wr_en;
    logic [pfa_pkg::PAGE_W-1:0] tbl_wr_addr;
    pfa_pkg::t_entry            tbl_wr_data;

    pfa_clear u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_clr   (clr)
    );

    pfa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clr         (clr),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_item    (o_out_item),
        .o_tbl         (tbl),
        .i_tbl_rd_data (tbl_rd_data),
        .o_stk         (stk),
        .i_stk_rd_data (stk_rd_data)
    );

    // The clearing sweep owns the table write port until it finishes.
    always_comb begin
        if (clr.busy) begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = clr.addr;
            tbl_wr_data = '0;
        end else begin
            tbl_wr_en   = tbl.wr_en;
            tbl_wr_addr = tbl.wr_addr;
            tbl_wr_data = tbl.wr_data;
        end
    end

    // Frame table: count, managed flag and free flag per frame.
    pfa_ram #(
        .WIDTH ($bits(pfa_pkg::t_entry)),
        .DEPTH (pfa_pkg::NUM_PAGES_INT)
    ) u_tbl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .i_rd_en   (tbl.rd_en),
        .i_rd_addr (tbl.rd_addr),
        .o_rd_data (tbl_rd_data)
    );

    // Free stack of frame indexes.
    pfa_ram #(
        .WIDTH (pfa_pkg::PAGE_W),
        .DEPTH (pfa_pkg::NUM_PAGES_INT)
    ) u_stk_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stk.wr_en),
        .i_wr_addr (stk.wr_addr),
        .i_wr_data (stk.wr_data),
        .i_rd_en   (stk.rd_en),
        .i_rd_addr (stk.rd_addr),
        .o_rd_data (stk_rd_data)
    );

endmodule
